FILE: sv/loas_pkg.sv
// Shared types for the LOAS/LATM to ADTS repacker.
// Holds the port payload structs and the command that passes from the
// front parser to the back emitter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package loas_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       unit_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_first;
		logic       frame_last;
		logic       frame_abort;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_ABORT  = 2'd0,
		CMD_HEADER = 2'd1,
		CMD_DATA   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic [3:0]  rate;
		logic [2:0]  chan;
		logic [12:0] plen;
	} cmd_t;

	localparam int QDepth = 4;
	localparam int QAw    = 2;
	localparam int HdrBytes = 7;

endpackage
`default_nettype wire

FILE: sv/loas_front.sv
// Front parser: finds the LOAS sync, walks the StreamMuxConfig bit by bit
// and issues at most one command per byte. Depends on loas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module loas_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire loas_pkg::in_item_t item,
	output logic                   cmd_valid,
	output loas_pkg::cmd_t         cmd
);

	typedef enum logic [4:0] {
		PH_SEARCH, PH_LENLO, PH_USESAME, PH_VERSION, PH_SKIPHDR, PH_AOT, PH_RATE,
		PH_CHAN, PH_FLFLAG, PH_DEPCORE, PH_COREDELAY, PH_EXT, PH_EXT3, PH_FLT,
		PH_FLTDATA, PH_OTHER, PH_OTHESC, PH_OTHMORE, PH_OTHLAST, PH_CRC,
		PH_CRCBYTE, PH_SLOT, PH_PAYLOAD, PH_DISCARD
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [7:0]  prev_q, prev_d;
	logic [12:0] ebl_q, ebl_d;
	logic [15:0] res_q, res_d;
	logic [4:0]  fbl_q, fbl_d;
	logic        seen_q, seen_d;
	logic        cfg_q, cfg_d;
	logic [2:0]  flk_q, flk_d;
	logic [3:0]  rate_q, rate_d;
	logic [2:0]  chan_q, chan_d;
	logic [12:0] plen_q, plen_d;
	logic [12:0] pleft_q, pleft_d;

	// Walk the byte one bit at a time; each finished field picks the next phase
	always_comb begin
		logic        stop;
		logic [7:0]  v;
		logic [13:0] sum;
		logic [15:0] bits_after;
		logic [7:0]  b;
		ph_d = ph_q; prev_d = prev_q; ebl_d = ebl_q; res_d = res_q; fbl_d = fbl_q;
		seen_d = seen_q; cfg_d = cfg_q; flk_d = flk_q; rate_d = rate_q; chan_d = chan_q;
		plen_d = plen_q; pleft_d = pleft_q;
		cmd_valid = 1'b0;
		cmd = '0;
		stop = 1'b0;
		v = '0;
		sum = '0;
		bits_after = '0;
		b = item.data_byte;
		if (item.unit_start) begin
			if (ph_q == PH_PAYLOAD && pleft_q != '0) begin
				cmd_valid = 1'b1;
				cmd.kind = loas_pkg::CMD_ABORT;
			end
			seen_d = 1'b1; prev_d = '0; ebl_d = '0; pleft_d = '0;
			ph_d = PH_SEARCH; fbl_d = '0; res_d = '0;
		end
		if (!seen_d) begin
			stop = 1'b1;
		end else if (ph_d == PH_SEARCH) begin
			if (prev_d == 8'h56 && (b & 8'he0) == 8'he0) begin
				ebl_d = {b[4:0], 8'h00};
				ph_d = PH_LENLO; fbl_d = '0; res_d = '0;
			end else begin
				prev_d = b;
			end
		end else if (ph_d == PH_LENLO) begin
			ebl_d = ebl_d | {5'd0, b};
			prev_d = '0;
			res_d = '0;
			if (ebl_d == '0) begin
				ph_d = PH_SEARCH; fbl_d = '0;
			end else begin
				ph_d = PH_USESAME; fbl_d = 5'd1;
			end
		end else begin
			if (ebl_d != '0)
				ebl_d = ebl_d - 13'd1;
			for (int i = 7; i >= 0; i--) begin
				if (!stop) begin
					if (ph_d == PH_DISCARD || fbl_d == '0) begin
						stop = 1'b1;
					end else begin
						res_d = {res_d[14:0], b[i]};
						fbl_d = fbl_d - 5'd1;
						if (fbl_d == '0) begin
							v = res_d[7:0];
							case (ph_d)
								PH_USESAME: begin
									if (res_d == '0) begin
										cfg_d = 1'b0; ph_d = PH_VERSION; fbl_d = 5'd1;
									end else if (!cfg_d || flk_d != '0) begin
										ph_d = PH_DISCARD;
									end else begin
										plen_d = '0; ph_d = PH_SLOT; fbl_d = 5'd8;
									end
								end
								PH_VERSION: begin
									if (res_d != '0) ph_d = PH_DISCARD;
									else begin ph_d = PH_SKIPHDR; fbl_d = 5'd14; end
								end
								PH_SKIPHDR: begin ph_d = PH_AOT; fbl_d = 5'd5; end
								PH_AOT: begin
									if (res_d != 16'd2) ph_d = PH_DISCARD;
									else begin ph_d = PH_RATE; fbl_d = 5'd4; end
								end
								PH_RATE: begin
									rate_d = v[3:0];
									if (v[3:0] == 4'hf) ph_d = PH_DISCARD;
									else begin ph_d = PH_CHAN; fbl_d = 5'd4; end
								end
								PH_CHAN: begin
									chan_d = v[2:0]; ph_d = PH_FLFLAG; fbl_d = 5'd1;
								end
								PH_FLFLAG: begin ph_d = PH_DEPCORE; fbl_d = 5'd1; end
								PH_DEPCORE: begin
									if (v[0]) begin ph_d = PH_COREDELAY; fbl_d = 5'd14; end
									else begin ph_d = PH_EXT; fbl_d = 5'd1; end
								end
								PH_COREDELAY: begin ph_d = PH_EXT; fbl_d = 5'd1; end
								PH_EXT: begin
									if (v[0]) begin ph_d = PH_EXT3; fbl_d = 5'd1; end
									else begin ph_d = PH_FLT; fbl_d = 5'd3; end
								end
								PH_EXT3: begin ph_d = PH_FLT; fbl_d = 5'd3; end
								PH_FLT: begin
									flk_d = v[2:0];
									case (v[2:0])
										3'd0: begin ph_d = PH_FLTDATA; fbl_d = 5'd8; end
										3'd1: begin ph_d = PH_FLTDATA; fbl_d = 5'd9; end
										3'd2: begin ph_d = PH_OTHER; fbl_d = 5'd1; end
										3'd3, 3'd4, 3'd5: begin
											ph_d = PH_FLTDATA; fbl_d = 5'd6;
										end
										default: begin ph_d = PH_FLTDATA; fbl_d = 5'd1; end
									endcase
								end
								PH_FLTDATA: begin ph_d = PH_OTHER; fbl_d = 5'd1; end
								PH_OTHER: begin
									if (v[0]) begin ph_d = PH_OTHESC; fbl_d = 5'd1; end
									else begin ph_d = PH_CRC; fbl_d = 5'd1; end
								end
								PH_OTHESC: begin
									ph_d = v[0] ? PH_OTHMORE : PH_OTHLAST; fbl_d = 5'd8;
								end
								PH_OTHMORE: begin ph_d = PH_OTHESC; fbl_d = 5'd1; end
								PH_OTHLAST: begin ph_d = PH_CRC; fbl_d = 5'd1; end
								PH_CRC, PH_CRCBYTE: begin
									if (ph_d == PH_CRC && v[0]) begin
										ph_d = PH_CRCBYTE; fbl_d = 5'd8;
									end else begin
										cfg_d = 1'b1;
										if (flk_d != '0) ph_d = PH_DISCARD;
										else begin
											plen_d = '0; ph_d = PH_SLOT; fbl_d = 5'd8;
										end
									end
								end
								PH_SLOT: begin
									sum = {1'b0, plen_d} + {6'd0, v};
									plen_d = (sum > 14'd8191) ? 13'h1fff : sum[12:0];
									bits_after = {ebl_d, 3'(i)};
									if (v == 8'hff) begin
										ph_d = PH_SLOT; fbl_d = 5'd8;
									end else if ({plen_d, 3'b000} > bits_after) begin
										ph_d = PH_DISCARD;
									end else begin
										cmd_valid = 1'b1;
										cmd.kind = loas_pkg::CMD_HEADER;
										cmd.last = (plen_d == '0);
										cmd.rate = rate_d;
										cmd.chan = chan_d;
										cmd.plen = plen_d;
										pleft_d = plen_d;
										if (plen_d == '0) ph_d = PH_DISCARD;
										else begin ph_d = PH_PAYLOAD; fbl_d = 5'd8; end
									end
								end
								PH_PAYLOAD: begin
									if (pleft_d != '0) pleft_d = pleft_d - 13'd1;
									cmd_valid = 1'b1;
									cmd.kind = loas_pkg::CMD_DATA;
									cmd.data = v;
									cmd.last = (pleft_d == '0);
									if (pleft_d == '0) ph_d = PH_DISCARD;
									else begin ph_d = PH_PAYLOAD; fbl_d = 5'd8; end
								end
								default: ph_d = PH_DISCARD;
							endcase
							res_d = '0;
						end
					end
				end
			end
			// Element exhausted: back to the sync search
			if (ebl_d == '0) begin
				prev_d = '0; pleft_d = '0;
				ph_d = PH_SEARCH; fbl_d = '0; res_d = '0;
			end
		end
		if (!take)
			cmd_valid = 1'b0;
	end

	// Hold parser state; advance only on an accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_SEARCH; prev_q <= '0; ebl_q <= '0; res_q <= '0; fbl_q <= '0;
			seen_q <= 1'b0; cfg_q <= 1'b0; flk_q <= '0; rate_q <= '0; chan_q <= '0;
			plen_q <= '0; pleft_q <= '0;
		end else if (take) begin
			ph_q <= ph_d; prev_q <= prev_d; ebl_q <= ebl_d; res_q <= res_d; fbl_q <= fbl_d;
			seen_q <= seen_d; cfg_q <= cfg_d; flk_q <= flk_d; rate_q <= rate_d;
			chan_q <= chan_d; plen_q <= plen_d; pleft_q <= pleft_d;
		end
	end

	ap_fbl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fbl_q <= 5'd14) else $error("field width out of range");
	ap_pay_left: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_PAYLOAD |-> pleft_q != '0) else $error("payload phase with nothing owed");
	ap_pay_fits: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_PAYLOAD |-> pleft_q <= plen_q) else $error("payload count exceeds slot");

endmodule
`default_nettype wire

FILE: sv/loas_cmdq.sv
// Short command queue between the front parser and the back emitter.
// Depends on loas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module loas_cmdq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire loas_pkg::cmd_t wdata,
	input  wire logic           rd,
	output loas_pkg::cmd_t      rdata,
	output logic                full,
	output logic                nempty
);

	loas_pkg::cmd_t             mem_q [loas_pkg::QDepth];
	logic [loas_pkg::QAw-1:0]   wp_q, rp_q;
	logic [loas_pkg::QAw:0]     cnt_q;

	assign full   = (cnt_q == (loas_pkg::QAw+1)'(loas_pkg::QDepth));
	assign nempty = (cnt_q != '0);
	assign rdata  = mem_q[rp_q];

	// Store a command beat
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			if (wr && !rd) cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	ap_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr) else $error("write to full queue");
	ap_no_unf: assert property (@(posedge clk) disable iff (!arst_n)
		!nempty |-> !rd) else $error("read from empty queue");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !rd |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule
`default_nettype wire

FILE: sv/loas_back.sv
// Back emitter: expands header commands into seven ADTS bytes and passes
// payload and abort beats through. Depends on loas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module loas_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire loas_pkg::cmd_t    qdata,
	input  wire logic              qvalid,
	output logic                   qrd,
	input  wire logic              pop,
	output logic                   empty,
	output loas_pkg::out_item_t    out_item
);

	loas_pkg::cmd_t cur_q;
	logic           vld_q;
	logic [2:0]     beat_q;
	logic           done;
	logic [12:0]    flen;

	assign flen  = cur_q.plen + 13'd7;
	assign empty = !vld_q;
	assign done  = vld_q && pop &&
		(cur_q.kind != loas_pkg::CMD_HEADER || beat_q == 3'(loas_pkg::HdrBytes - 1));
	assign qrd   = qvalid && (!vld_q || done);

	// Form the current beat
	always_comb begin
		out_item = '0;
		case (cur_q.kind)
			loas_pkg::CMD_ABORT: out_item.frame_abort = 1'b1;
			loas_pkg::CMD_DATA: begin
				out_item.out_byte   = cur_q.data;
				out_item.frame_last = cur_q.last;
			end
			loas_pkg::CMD_HEADER: begin
				case (beat_q)
					3'd0: begin out_item.out_byte = 8'hff; out_item.frame_first = 1'b1; end
					3'd1: out_item.out_byte = 8'hf1;
					3'd2: out_item.out_byte = {2'b01, cur_q.rate, 1'b1, cur_q.chan[2]};
					3'd3: out_item.out_byte = {cur_q.chan[1:0], 4'hf, flen[12:11]};
					3'd4: out_item.out_byte = flen[10:3];
					3'd5: out_item.out_byte = {flen[2:0], 5'd0};
					default: begin out_item.out_byte = 8'h00; out_item.frame_last = cur_q.last; end
				endcase
			end
			default: out_item = '0;
		endcase
	end

	// Hold or advance the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0; beat_q <= '0; cur_q <= '0;
		end else if (qrd) begin
			cur_q <= qdata; vld_q <= 1'b1; beat_q <= '0;
		end else if (done) begin
			vld_q <= 1'b0; beat_q <= '0;
		end else if (vld_q && pop) begin
			beat_q <= beat_q + 3'd1;
		end
	end

	ap_abort_alone: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && out_item.frame_abort |-> !out_item.frame_first && !out_item.frame_last)
		else $error("abort beat carries frame marks");
	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !pop |=> vld_q && $stable(beat_q)) else $error("beat lost under stall");
	ap_beat_step: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && pop && !done |=> beat_q == $past(beat_q) + 3'd1) else $error("header skip");

endmodule
`default_nettype wire

FILE: sv/loas_latm_to_adts.sv
// LOAS/LATM to ADTS repacker top level.
// Depends on loas_pkg, loas_front, loas_cmdq and loas_back.
//
// Input channel: push with in_item (data_byte, unit_start); a beat is taken
// when push is high and full is low. Output channel: out_item is valid while
// empty is low and is taken when pop is high.
// The front parser takes one byte per cycle while full is low and issues
// at most one command per byte into a four-entry queue. A payload or abort
// command leaves as one beat; a header command leaves as seven beats, one
// per cycle while pop is high. Header bursts are absorbed by the queue, and
// full rises when it fills, driven by the header expansion in the back
// emitter.
// Reset clears the parser to the sync search with no configuration, empties
// the queue and drops any beat in flight. A stalled receiver holds the
// current beat; the queue then fills and full stalls the sender.
`timescale 1ns / 1ps
`default_nettype none
module loas_latm_to_adts (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire loas_pkg::in_item_t   in_item,
	output logic                      empty,
	input  wire logic                 pop,
	output loas_pkg::out_item_t       out_item
);

	logic           take;
	logic           cmd_valid;
	loas_pkg::cmd_t cmd;
	loas_pkg::cmd_t qdata;
	logic           qvalid;
	logic           qrd;

	assign take = push && !full;

	loas_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .item(in_item),
		.cmd_valid(cmd_valid), .cmd(cmd)
	);

	loas_cmdq u_cmdq (
		.clk(clk), .arst_n(arst_n), .wr(cmd_valid), .wdata(cmd),
		.rd(qrd), .rdata(qdata), .full(full), .nempty(qvalid)
	);

	loas_back u_back (
		.clk(clk), .arst_n(arst_n), .qdata(qdata), .qvalid(qvalid), .qrd(qrd),
		.pop(pop), .empty(empty), .out_item(out_item)
	);

endmodule
`default_nettype wire
